@@ src/atb_pkg.sv @@
// Shared constants and codes for the alias table sampler.
package atb_pkg;

  localparam int MAX_ENTRIES = 128;
  localparam int VALUE_BITS  = 11;
  localparam int FRAC_BITS   = 24;

  localparam int IDX_W     = $clog2(MAX_ENTRIES);
  localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int WEIGHT_W  = 32;
  localparam int SUM_W     = WEIGHT_W + IDX_W;
  localparam int SCALED_W  = FRAC_BITS + CNT_W;
  localparam int PROB_W    = FRAC_BITS + 1;
  localparam int NUM_W     = WEIGHT_W + CNT_W;
  localparam int DIV_W     = NUM_W + FRAC_BITS;
  localparam int DIVC_W    = $clog2(DIV_W);
  localparam int REM_W     = SUM_W + 1;
  localparam int SAMPLE_W  = VALUE_BITS + 1;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;

  localparam logic [SCALED_W-1:0] ONE_SCALED = SCALED_W'(1) << FRAC_BITS;
  localparam logic [PROB_W-1:0]   ONE_PROB   = PROB_W'(1) << FRAC_BITS;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

endpackage

@@ src/atb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module atb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/alias_table_build_and_sample.sv @@
// Top level of the alias table sampler: loading, table build and sampling.
//
// Items arrive on the in_ channel; in_tuser carries the operation (clear,
// load, sample) and in_tlast marks the final loaded entry. Every item gives
// exactly one result item on the out_ channel with the sampled value, a
// status code and the current entry count. The base offset is written on
// the cfg_ port; the user must write it only while the block is idle, as
// the block does not enforce this. A clear or load result is registered at
// once; a sample reads probability and alias on acceptance, the chosen
// value in state S_S1, and registers its result in state S_S2. The load
// that carries in_tlast starts the build from the table memories: for each
// entry one memory read, a multiply and a 64-step restoring divider, then
// a pairing step per small/large pair and a step per leftover entry. No
// item is accepted during the build. Reset empties the table and clears
// the base offset; the memories keep their contents. A result waits in
// the output register while the receiver stalls, and a new item is taken
// as soon as that register can be freed.
module alias_table_build_and_sample
  import atb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // entry_value[10:0], entry_weight[42:11], rand_index[49:43],
  // rand_fraction[73:50], zero fill above.
  input  logic [79:0]          in_tdata,
  // op
  input  logic [OP_W-1:0]      in_tuser,
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // sample_value[11:0], entry_count[19:12], zero fill above.
  output logic [23:0]          out_tdata,
  // status
  output logic [STATUS_W-1:0]  out_tuser,
  input  logic                 cfg_we,
  input  logic [VALUE_BITS-1:0] cfg_wdata
);

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_BST   = 18'h00002,
    S_ZF    = 18'h00004,
    S_C0    = 18'h00008,
    S_C1    = 18'h00010,
    S_C2    = 18'h00020,
    S_C3    = 18'h00040,
    S_PCHK  = 18'h00080,
    S_P0    = 18'h00100,
    S_P1    = 18'h00200,
    S_P2    = 18'h00400,
    S_P3    = 18'h00800,
    S_LG0   = 18'h01000,
    S_LG1   = 18'h02000,
    S_SM0   = 18'h04000,
    S_SM1   = 18'h08000,
    S_S1    = 18'h10000,
    S_S2    = 18'h20000
  } state_t;

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [CNT_W:0] s);
    logic [CNT_W:0] t;
    t = s;
    if (s >= (CNT_W+1)'(MAX_ENTRIES)) begin
      t = s - (CNT_W+1)'(MAX_ENTRIES);
    end
    return t[IDX_W-1:0];
  endfunction

  logic [VALUE_BITS-1:0] in_value;
  logic [WEIGHT_W-1:0]   in_weight;
  logic [IDX_W-1:0]      in_index;
  logic [FRAC_BITS-1:0]  in_frac;
  logic                  in_acc;

  assign in_value  = in_tdata[10:0];
  assign in_weight = in_tdata[42:11];
  assign in_index  = in_tdata[49:43];
  assign in_frac   = in_tdata[73:50];

  state_t                state_r, state_nxt;
  logic [VALUE_BITS-1:0] base_r, base_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic                  ready_r, ready_nxt;
  logic [IDX_W-1:0]      sh_r, sh_nxt, gh_r, gh_nxt;
  logic [CNT_W-1:0]      slen_r, slen_nxt, glen_r, glen_nxt;
  logic [IDX_W-1:0]      i_r, i_nxt;
  logic [IDX_W-1:0]      l_r, l_nxt, g_r, g_nxt;
  logic [SCALED_W-1:0]   sl_r, sl_nxt;
  logic [DIV_W-1:0]      dvd_r, dvd_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [SCALED_W-1:0]   quo_r, quo_nxt;
  logic [DIVC_W-1:0]     dcnt_r, dcnt_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [FRAC_BITS-1:0]  frac_r, frac_nxt;
  logic                  ov_r, ov_nxt;
  logic [SAMPLE_W-1:0]   osmp_r, osmp_nxt;
  logic [STATUS_W-1:0]   ost_r, ost_nxt;
  logic [CNT_W-1:0]      ocnt_r, ocnt_nxt;

  logic                  val_we;
  logic [IDX_W-1:0]      val_wa, val_ra;
  logic [VALUE_BITS-1:0] val_wd, val_rd;
  logic                  scl_we;
  logic [IDX_W-1:0]      scl_wa, scl_ra;
  logic [SCALED_W-1:0]   scl_wd, scl_rd;
  logic                  prb_we;
  logic [IDX_W-1:0]      prb_wa, prb_ra;
  logic [PROB_W-1:0]     prb_wd, prb_rd;
  logic                  als_we;
  logic [IDX_W-1:0]      als_wa, als_ra;
  logic [IDX_W-1:0]      als_wd, als_rd;
  logic                  sml_we;
  logic [IDX_W-1:0]      sml_wa, sml_ra, sml_wd, sml_rd;
  logic                  lrg_we;
  logic [IDX_W-1:0]      lrg_wa, lrg_ra, lrg_wd, lrg_rd;

  logic [REM_W-1:0]      rem_sh;
  logic [SCALED_W:0]     g_sum;
  logic [SCALED_W-1:0]   g_new;
  logic [IDX_W-1:0]      sh1, gh1;
  logic [CNT_W-1:0]      slen1, glen1;
  logic [IDX_W-1:0]      pick;

  assign in_tready = (state_r == S_IDLE) && (!ov_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  assign rem_sh = {rem_r[REM_W-2:0], dvd_r[DIV_W-1]};
  assign g_sum  = {1'b0, scl_rd} + {1'b0, sl_r} - {1'b0, ONE_SCALED};
  assign g_new  = g_sum[SCALED_W-1:0];
  assign sh1    = wrap_idx({1'b0, CNT_W'(sh_r)} + (CNT_W+1)'(1));
  assign gh1    = wrap_idx({1'b0, CNT_W'(gh_r)} + (CNT_W+1)'(1));
  assign slen1  = slen_r - CNT_W'(1);
  assign glen1  = glen_r - CNT_W'(1);
  assign pick   = ({1'b0, frac_r} > prb_rd) ? als_rd : idx_r;

  always_comb begin
    state_nxt = state_r;
    base_nxt  = cfg_we ? cfg_wdata : base_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    ready_nxt = ready_r;
    sh_nxt    = sh_r;
    gh_nxt    = gh_r;
    slen_nxt  = slen_r;
    glen_nxt  = glen_r;
    i_nxt     = i_r;
    l_nxt     = l_r;
    g_nxt     = g_r;
    sl_nxt    = sl_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dcnt_nxt  = dcnt_r;
    idx_nxt   = idx_r;
    frac_nxt  = frac_r;
    ov_nxt    = ov_r && !out_tready;
    osmp_nxt  = osmp_r;
    ost_nxt   = ost_r;
    ocnt_nxt  = ocnt_r;

    val_we = 1'b0; val_wa = count_r[IDX_W-1:0]; val_wd = in_value; val_ra = pick;
    scl_we = 1'b0; scl_wa = i_r; scl_wd = quo_r; scl_ra = i_r;
    prb_we = 1'b0; prb_wa = i_r; prb_wd = ONE_PROB; prb_ra = in_index;
    als_we = 1'b0; als_wa = i_r; als_wd = i_r; als_ra = in_index;
    sml_we = 1'b0; sml_wa = wrap_idx({1'b0, CNT_W'(sh_r) + slen_r}); sml_wd = i_r;
    sml_ra = sh_r;
    lrg_we = 1'b0; lrg_wa = wrap_idx({1'b0, CNT_W'(gh_r) + glen_r}); lrg_wd = i_r;
    lrg_ra = gh_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ov_nxt   = 1'b1;
          osmp_nxt = '0;
          ost_nxt  = ST_OK;
          ocnt_nxt = count_r;
          priority if (in_tuser == OP_CLEAR) begin
            count_nxt = '0;
            sum_nxt   = '0;
            ready_nxt = 1'b0;
            ocnt_nxt  = '0;
          end else if (in_tuser == OP_LOAD) begin
            if (ready_r) begin
              ost_nxt = ST_FULL;
            end else begin
              if (count_r >= CNT_W'(MAX_ENTRIES)) begin
                ost_nxt = ST_FULL;
              end else begin
                val_we    = 1'b1;
                scl_we    = 1'b1;
                scl_wa    = count_r[IDX_W-1:0];
                scl_wd    = in_weight;
                sum_nxt   = sum_r + SUM_W'(in_weight);
                count_nxt = count_r + CNT_W'(1);
                ocnt_nxt  = count_r + CNT_W'(1);
              end
              if (in_tlast) begin
                state_nxt = S_BST;
              end
            end
          end else if (in_tuser == OP_SAMPLE) begin
            if (!ready_r) begin
              ost_nxt = ST_NOT_READY;
            end else if (CNT_W'(in_index) >= count_r) begin
              ost_nxt = ST_RANGE;
            end else begin
              ov_nxt    = 1'b0;
              idx_nxt   = in_index;
              frac_nxt  = in_frac;
              state_nxt = S_S1;
            end
          end else begin
            ost_nxt = ST_OK;
          end
        end
      end
      S_S1: begin
        state_nxt = S_S2;
      end
      S_S2: begin
        ov_nxt    = 1'b1;
        osmp_nxt  = SAMPLE_W'(base_r) + SAMPLE_W'(val_rd);
        ost_nxt   = ST_OK;
        ocnt_nxt  = count_r;
        state_nxt = S_IDLE;
      end
      S_BST: begin
        sh_nxt   = '0;
        gh_nxt   = '0;
        slen_nxt = '0;
        glen_nxt = '0;
        i_nxt    = '0;
        if (count_r == '0) begin
          ready_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (sum_r == '0) begin
          state_nxt = S_ZF;
        end else begin
          state_nxt = S_C0;
        end
      end
      S_ZF: begin
        prb_we = 1'b1;
        als_we = 1'b1;
        i_nxt  = i_r + IDX_W'(1);
        if (CNT_W'(i_r) == count_r - CNT_W'(1)) begin
          ready_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_C0: begin
        state_nxt = S_C1;
      end
      S_C1: begin
        dvd_nxt   = {NUM_W'(scl_rd) * NUM_W'(count_r), FRAC_BITS'(0)};
        rem_nxt   = '0;
        quo_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = S_C2;
      end
      S_C2: begin
        dvd_nxt  = {dvd_r[DIV_W-2:0], 1'b0};
        dcnt_nxt = dcnt_r + DIVC_W'(1);
        if (rem_sh >= {1'b0, sum_r}) begin
          rem_nxt = rem_sh - {1'b0, sum_r};
          quo_nxt = {quo_r[SCALED_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[SCALED_W-2:0], 1'b0};
        end
        if (dcnt_r == DIVC_W'(DIV_W - 1)) begin
          state_nxt = S_C3;
        end
      end
      S_C3: begin
        scl_we = 1'b1;
        als_we = 1'b1;
        if (quo_r < ONE_SCALED) begin
          sml_we   = 1'b1;
          slen_nxt = slen_r + CNT_W'(1);
        end else begin
          lrg_we   = 1'b1;
          glen_nxt = glen_r + CNT_W'(1);
        end
        i_nxt = i_r + IDX_W'(1);
        if (CNT_W'(i_r) == count_r - CNT_W'(1)) begin
          state_nxt = S_PCHK;
        end else begin
          state_nxt = S_C0;
        end
      end
      S_PCHK: begin
        if (slen_r != '0 && glen_r != '0) begin
          state_nxt = S_P0;
        end else begin
          state_nxt = S_LG0;
        end
      end
      S_P0: begin
        state_nxt = S_P1;
      end
      S_P1: begin
        l_nxt     = sml_rd;
        g_nxt     = lrg_rd;
        scl_ra    = sml_rd;
        state_nxt = S_P2;
      end
      S_P2: begin
        sl_nxt    = scl_rd;
        scl_ra    = g_r;
        state_nxt = S_P3;
      end
      S_P3: begin
        prb_we   = 1'b1;
        prb_wa   = l_r;
        prb_wd   = sl_r[PROB_W-1:0];
        als_we   = 1'b1;
        als_wa   = l_r;
        als_wd   = g_r;
        scl_we   = 1'b1;
        scl_wa   = g_r;
        scl_wd   = g_new;
        sh_nxt   = sh1;
        gh_nxt   = gh1;
        slen_nxt = slen1;
        glen_nxt = glen1;
        if (g_new < ONE_SCALED) begin
          sml_we   = 1'b1;
          sml_wa   = wrap_idx({1'b0, CNT_W'(sh1) + slen1});
          sml_wd   = g_r;
          slen_nxt = slen_r;
        end else begin
          lrg_we   = 1'b1;
          lrg_wa   = wrap_idx({1'b0, CNT_W'(gh1) + glen1});
          lrg_wd   = g_r;
          glen_nxt = glen_r;
        end
        state_nxt = S_PCHK;
      end
      S_LG0: begin
        if (glen_r != '0) begin
          state_nxt = S_LG1;
        end else begin
          state_nxt = S_SM0;
        end
      end
      S_LG1: begin
        prb_we    = 1'b1;
        prb_wa    = lrg_rd;
        als_we    = 1'b1;
        als_wa    = lrg_rd;
        als_wd    = lrg_rd;
        gh_nxt    = gh1;
        glen_nxt  = glen1;
        state_nxt = S_LG0;
      end
      S_SM0: begin
        if (slen_r != '0) begin
          state_nxt = S_SM1;
        end else begin
          ready_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SM1: begin
        prb_we    = 1'b1;
        prb_wa    = sml_rd;
        als_we    = 1'b1;
        als_wa    = sml_rd;
        als_wd    = sml_rd;
        sh_nxt    = sh1;
        slen_nxt  = slen1;
        state_nxt = S_SM0;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      base_r  <= '0;
      count_r <= '0;
      sum_r   <= '0;
      ready_r <= 1'b0;
      sh_r    <= '0;
      gh_r    <= '0;
      slen_r  <= '0;
      glen_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      base_r  <= base_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      ready_r <= ready_nxt;
      sh_r    <= sh_nxt;
      gh_r    <= gh_nxt;
      slen_r  <= slen_nxt;
      glen_r  <= glen_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    l_r    <= l_nxt;
    g_r    <= g_nxt;
    sl_r   <= sl_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dcnt_r <= dcnt_nxt;
    idx_r  <= idx_nxt;
    frac_r <= frac_nxt;
    osmp_r <= osmp_nxt;
    ost_r  <= ost_nxt;
    ocnt_r <= ocnt_nxt;
  end

  atb_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ENTRIES)) u_value (
    .clk(clk), .we(val_we), .waddr(val_wa), .wdata(val_wd), .raddr(val_ra), .rdata(val_rd)
  );

  atb_ram #(.WIDTH(SCALED_W), .DEPTH(MAX_ENTRIES)) u_scaled (
    .clk(clk), .we(scl_we), .waddr(scl_wa), .wdata(scl_wd), .raddr(scl_ra), .rdata(scl_rd)
  );

  atb_ram #(.WIDTH(PROB_W), .DEPTH(MAX_ENTRIES)) u_prob (
    .clk(clk), .we(prb_we), .waddr(prb_wa), .wdata(prb_wd), .raddr(prb_ra), .rdata(prb_rd)
  );

  atb_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_alias (
    .clk(clk), .we(als_we), .waddr(als_wa), .wdata(als_wd), .raddr(als_ra), .rdata(als_rd)
  );

  atb_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_small (
    .clk(clk), .we(sml_we), .waddr(sml_wa), .wdata(sml_wd), .raddr(sml_ra), .rdata(sml_rd)
  );

  atb_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_large (
    .clk(clk), .we(lrg_we), .waddr(lrg_wa), .wdata(lrg_wd), .raddr(lrg_ra), .rdata(lrg_rd)
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = {4'b0, ocnt_r, osmp_r};
  assign out_tuser  = ost_r;

`ifndef ASSERT_OFF
  a_lists_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> ((CNT_W+1)'(slen_r) + (CNT_W+1)'(glen_r)
                             <= (CNT_W+1)'(count_r)))
    else $error("worklists hold more entries than are loaded");
  a_large_at_least_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P3) |-> (scl_rd >= ONE_SCALED))
    else $error("entry from the large list is below one");
  a_sample_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_S1) |-> (ready_r && CNT_W'(idx_r) < count_r && !ov_r))
    else $error("sample lookup without a ready table or free output");
`endif

endmodule

@@ tb/sv/alias_table_build_and_sample_tb.sv @@
// Self-checking testbench for the alias table sampler with a built-in table predictor.
module alias_table_build_and_sample_tb;
  import atb_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int BUILD_WAIT = 12000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [STATUS_W-1:0] status;
    logic [7:0]          count;
  } result_t;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [10:0]      val;
    logic [31:0]      weight;
    logic             last;
    logic [6:0]       idx;
    logic [23:0]      frac;
    bit               typed;
    result_t          want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [79:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [STATUS_W-1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [VALUE_BITS-1:0] cfg_wdata = '0;

  alias_table_build_and_sample dut (.*);

  always #1 clk = ~clk;

  // Predicted table state.
  logic [10:0]         val_mem [MAX_ENTRIES];
  logic [31:0]         wgt_mem [MAX_ENTRIES];
  longint unsigned     scl_mem [MAX_ENTRIES];
  logic [PROB_W-1:0]   prob_mem [MAX_ENTRIES];
  logic [6:0]          alias_mem [MAX_ENTRIES];
  int                  held;
  longint unsigned     wsum;
  bit                  ready;
  logic [10:0]         offset;

  result_t expected_results[$];
  int errors = 0;
  int items_sent = 0;
  bit quiet = 0;
  int stall_left = 0;

  task automatic build_alias_table();
    int small_q[$];
    int large_q[$];
    int n;
    int l;
    int g;
    n = held;
    if (wsum == 0) begin
      for (int i = 0; i < n; i++) begin
        prob_mem[i] = ONE_PROB;
        alias_mem[i] = i;
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        scl_mem[i] = ((longint'(wgt_mem[i]) * n) << FRAC_BITS) / wsum;
        alias_mem[i] = i;
        if (scl_mem[i] < ONE_SCALED) small_q.push_back(i);
        else large_q.push_back(i);
      end
      while (small_q.size() != 0 && large_q.size() != 0) begin
        l = small_q.pop_front();
        g = large_q.pop_front();
        prob_mem[l] = scl_mem[l];
        alias_mem[l] = g;
        scl_mem[g] = scl_mem[g] + scl_mem[l] - ONE_SCALED;
        if (scl_mem[g] < ONE_SCALED) small_q.push_back(g);
        else large_q.push_back(g);
      end
      while (large_q.size() != 0) begin
        g = large_q.pop_front();
        prob_mem[g] = ONE_PROB;
        alias_mem[g] = g;
      end
      while (small_q.size() != 0) begin
        l = small_q.pop_front();
        prob_mem[l] = ONE_PROB;
        alias_mem[l] = l;
      end
    end
    ready = 1;
  endtask

  task automatic predict_item(input row_t r, output result_t res);
    int pick;
    res = '0;
    if (r.op == OP_CLEAR) begin
      held = 0;
      wsum = 0;
      ready = 0;
    end else if (r.op == OP_LOAD) begin
      if (ready) begin
        res.status = ST_FULL;
      end else begin
        if (held >= MAX_ENTRIES) begin
          res.status = ST_FULL;
        end else begin
          val_mem[held] = r.val;
          wgt_mem[held] = r.weight;
          wsum += r.weight;
          held++;
        end
        if (r.last) build_alias_table();
      end
    end else if (r.op == OP_SAMPLE) begin
      if (!ready) begin
        res.status = ST_NOT_READY;
      end else if (r.idx >= held) begin
        res.status = ST_RANGE;
      end else begin
        pick = r.idx;
        if (r.frac > prob_mem[r.idx]) pick = alias_mem[r.idx];
        res.value = SAMPLE_W'(offset) + SAMPLE_W'(val_mem[pick]);
      end
    end
    res.count = held;
  endtask

  task automatic send_item(input row_t r);
    result_t res;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.op;
    in_tlast <= r.last;
    in_tdata <= {6'b0, r.frac, r.idx, r.weight, r.val};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_item(r, res);
    expected_results.push_back(r.typed ? r.want : res);
    items_sent++;
  endtask

  task automatic go_idle_and_write(input logic [10:0] v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (BUILD_WAIT) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    offset = v;
  endtask

  function automatic row_t mk(logic [1:0] op, logic [10:0] v, logic [31:0] w, logic last,
                              logic [6:0] idx, logic [23:0] frac);
    row_t r;
    r.op = op; r.val = v; r.weight = w; r.last = last; r.idx = idx; r.frac = frac;
    r.typed = 0; r.want = '0;
    return r;
  endfunction

  function automatic row_t mkt(logic [1:0] op, logic [10:0] v, logic [31:0] w, logic last,
                               logic [6:0] idx, logic [23:0] frac, logic [1:0] st, int cnt);
    row_t r;
    r = mk(op, v, w, last, idx, frac);
    r.typed = 1;
    r.want.value = '0;
    r.want.status = st;
    r.want.count = cnt;
    return r;
  endfunction

  function automatic logic [31:0] rand_weight(int style);
    case (style)
      0: return 32'h0;
      1: return $urandom_range(0, 255);
      2: return 32'h4000_0000;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      out_tready <= rst_n;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 17);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.value = out_tdata[11:0];
      got.count = out_tdata[19:12];
      got.status = out_tuser;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item: %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected value %0d status %0d count %0d, got %0d %0d %0d",
                     want.value, want.status, want.count, got.value, got.status, got.count);
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("alias_table_build_and_sample_tb NOT OK");
    $finish;
  end

  initial begin
    row_t dir [$];
    row_t r;
    int n;
    int style;
    int same_w;
    bit zero_written;
    held = 0; wsum = 0; ready = 0; offset = '0;
    zero_written = 0;
    dir.push_back(mkt(OP_SAMPLE, 0, 0, 0, 0, 0, ST_NOT_READY, 0));
    dir.push_back(mkt(OP_LOAD, 2047, 32'hFFFF_FFFF, 0, 0, 0, ST_OK, 1));
    dir.push_back(mkt(OP_LOAD, 0, 32'h0, 0, 0, 0, ST_OK, 2));
    dir.push_back(mkt(OP_LOAD, 5, 32'h8000_0000, 1, 0, 0, ST_OK, 3));
    dir.push_back(mkt(OP_LOAD, 11, 32'h1234, 1, 0, 0, ST_FULL, 3));
    dir.push_back(mk(OP_SAMPLE, 0, 0, 0, 0, 24'h0));
    dir.push_back(mk(OP_SAMPLE, 0, 0, 0, 1, 24'hFFFFFF));
    dir.push_back(mk(OP_SAMPLE, 0, 0, 0, 2, 24'h800000));
    dir.push_back(mk(OP_SAMPLE, 0, 0, 0, 0, 24'hFFFFFF));
    dir.push_back(mkt(OP_SAMPLE, 0, 0, 0, 3, 24'h1, ST_RANGE, 3));
    dir.push_back(mkt(OP_SAMPLE, 0, 0, 0, 127, 24'hFFFFFF, ST_RANGE, 3));
    dir.push_back(mkt(OP_UNUSED, 2047, 32'hFFFF_FFFF, 1, 127, 24'hFFFFFF, ST_OK, 3));
    dir.push_back(mkt(OP_CLEAR, 0, 0, 0, 0, 0, ST_OK, 0));
    dir.push_back(mkt(OP_SAMPLE, 0, 0, 0, 0, 0, ST_NOT_READY, 0));
    dir.push_back(mkt(OP_LOAD, 7, 32'h0, 0, 0, 0, ST_OK, 1));
    dir.push_back(mkt(OP_LOAD, 9, 32'h0, 1, 0, 0, ST_OK, 2));
    dir.push_back(mk(OP_SAMPLE, 0, 0, 0, 1, 24'hFFFFFF));
    dir.push_back(mk(OP_SAMPLE, 0, 0, 0, 0, 24'h0));
    dir.push_back(mkt(OP_CLEAR, 0, 0, 0, 0, 0, ST_OK, 0));
    dir.push_back(mkt(OP_LOAD, 100, 32'h1234, 1, 0, 0, ST_OK, 1));
    dir.push_back(mk(OP_SAMPLE, 0, 0, 0, 0, 24'hFFFFFF));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir[i]) send_item(dir[i]);

    go_idle_and_write(11'd2047);
    send_item(mk(OP_SAMPLE, 0, 0, 0, 0, 24'hFFFFFF));
    send_item(mk(OP_CLEAR, 0, 0, 0, 0, 0));
    for (int i = 0; i < 130; i++)
      send_item(mk(OP_LOAD, $urandom_range(0, 2047), $urandom, i == 129, 0, 0));
    for (int i = 0; i < 30; i++)
      send_item(mk(OP_SAMPLE, 0, 0, 0, $urandom_range(0, 127), $urandom));

    go_idle_and_write($urandom_range(1, 2046));
    while (items_sent < 600) begin
      if (items_sent > 520) quiet = 1;
      if (items_sent >= 400 && !zero_written) begin
        go_idle_and_write(11'd0);
        zero_written = 1;
      end
      if ($urandom_range(0, 9) < 8) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
        style = $urandom_range(0, 5);
        same_w = $urandom_range(0, 4) == 0;
        send_item(mk(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom));
        for (int i = 0; i < n; i++)
          send_item(mk(OP_LOAD, $urandom_range(0, 2047),
                       same_w ? 32'h2000_0000 : rand_weight(style), i == n - 1,
                       $urandom, $urandom));
        repeat ($urandom_range(4, 16)) begin
          r = mk(OP_SAMPLE, $urandom, $urandom, $urandom,
                 ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                             : $urandom_range(0, n - 1), $urandom);
          if ($urandom_range(0, 5) == 0) r.frac = $urandom_range(0, 1) ? 24'h0 : 24'hFFFFFF;
          send_item(r);
        end
      end else begin
        send_item(mk($urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom, $urandom));
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("alias_table_build_and_sample_tb OK");
    end else begin
      $display("alias_table_build_and_sample_tb NOT OK");
    end
    $finish;
  end

endmodule
